// ===== hdl/dtpg_pkg.sv =====
// shared types, codes and divider step functions for the test pattern generator
`timescale 1ns / 1ps

package dtpg_pkg;

    typedef enum logic [2:0] {
        PAT_SOLID    = 3'd0,
        PAT_GRADIENT = 3'd1,
        PAT_LINES    = 3'd2,
        PAT_CHESS    = 3'd3,
        PAT_MARKER   = 3'd4
    } pattern_t;

    typedef enum logic [1:0] {
        LM_CHECKER   = 2'd0,
        LM_ODD_INDEX = 2'd1,
        LM_ROWS      = 2'd2
    } line_mode_t;

    // one restoring step of the chess square divider
    typedef struct packed {
        logic       q;
        logic [7:0] rem;
    } cdiv_t;

    // one restoring step of the gradient divider
    typedef struct packed {
        logic        q;
        logic [10:0] rem;
    } gdiv_t;

    // configuration as seen by the datapath
    typedef struct packed {
        pattern_t    pattern;
        logic        odd;
        logic        w0;
        line_mode_t  line_mode;
        logic        solid_on;
        logic [2:0]  chan;
        logic [7:0]  chess_div;
        logic [10:0] grad_div;
        logic [11:0] col1;
        logic [11:0] col2;
        logic [11:0] col4;
        logic [11:0] col5;
        logic [11:0] row1;
        logic [11:0] row2;
        logic [11:0] row3;
        logic [11:0] row4;
        logic [11:0] row5;
        logic [11:0] row6;
    } cfg_t;

    // what the last divider stage hands to the output stage
    typedef struct packed {
        logic       cx;
        logic       cy;
        logic [7:0] gq;
        logic       govf;
        logic       mk_fg;
        logic       x0;
        logic       y0;
    } pix_t;

    function automatic cdiv_t chess_step(input logic [7:0] rem, input logic din,
                                         input logic [7:0] dv);
        logic [8:0] r;
        cdiv_t      res;
        r = {rem, din};
        if (r >= {1'b0, dv}) begin
            res.q   = 1'b1;
            res.rem = 8'(r - {1'b0, dv});
        end else begin
            res.q   = 1'b0;
            res.rem = r[7:0];
        end
        return res;
    endfunction

    function automatic gdiv_t grad_step(input logic [10:0] rem, input logic din,
                                        input logic [10:0] dv);
        logic [11:0] r;
        gdiv_t       res;
        r = {rem, din};
        if (r >= {1'b0, dv}) begin
            res.q   = 1'b1;
            res.rem = 11'(r - {1'b0, dv});
        end else begin
            res.q   = 1'b0;
            res.rem = r[10:0];
        end
        return res;
    endfunction

endpackage

// ===== hdl/display_test_pattern_generator.sv =====
// top level: stream handshake, valid tracking and the RGB565 output stage
//
//  channel  ports                 word
//  -------  --------------------  ----------------------------------------
//  s_       s_tvalid/s_tready     s_tdata: pixel_x [10:0], pixel_y [21:11]
//  m_       m_tvalid/m_tready     m_tdata: pixel_value [15:0]
//  cfg_     cfg_we (no handshake) cfg_index selects, cfg_data carries value
//
//  one word per cycle sustained while m_ does not stall, six register stages;
//  a word accepted on s_ passes stage registers 1 to 5, then the output register
//  the two dividers are pipelined two to three steps per stage
//  each stage moves when its successor has room, so bubbles close up and
//  a stalled m_ side fills the pipe before s_tready drops
//  reset is synchronous; s_tready is low while aresetn is low
`timescale 1ns / 1ps

module display_test_pattern_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pixel_x [10:0], pixel_y [21:11], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // pixel_value [15:0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);

    dtpg_pkg::cfg_t cfg;
    dtpg_pkg::pix_t pix;

    logic [5:0]  en;
    logic [4:0]  v_reg;
    logic [4:0]  v_next;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [15:0] pixel_reg;
    logic [15:0] pixel_next;
    logic        s_accept;
    logic [7:0]  gsat;
    logic [7:0]  gval;
    logic [15:0] color;
    logic [15:0] grad;
    logic        line_on;

    dtpg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dtpg_core u_core (
        .aclk    (aclk),
        .en      (en[4:0]),
        .pixel_x (s_tdata[10:0]),
        .pixel_y (s_tdata[21:11]),
        .cfg     (cfg),
        .pix     (pix)
    );

    // a stage loads when it is empty or the one after it loads
    always_comb begin
        en[5] = ~m_tvalid_reg | m_tready;
        for (int i = 4; i >= 0; i--) begin
            en[i] = ~v_reg[i] | en[i + 1];
        end
    end

    assign s_tready = en[0] & aresetn;
    assign s_accept = s_tvalid & s_tready;

    always_comb begin
        v_next = v_reg;
        if (en[0]) begin
            v_next[0] = s_accept;
        end
        for (int i = 1; i < 5; i++) begin
            if (en[i]) begin
                v_next[i] = v_reg[i - 1];
            end
        end
        m_tvalid_next = en[5] ? v_reg[4] : m_tvalid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg        <= 5'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            v_reg        <= v_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // color composition
    always_comb begin
        gsat  = pix.govf ? 8'hFF : pix.gq;
        gval  = cfg.odd ? ~gsat : gsat;
        color = {{5{cfg.chan[2]}}, {6{cfg.chan[1]}}, {5{cfg.chan[0]}}};
        grad  = {cfg.chan[2] ? gval[7:3] : 5'd0,
                 cfg.chan[1] ? gval[7:2] : 6'd0,
                 cfg.chan[0] ? gval[7:3] : 5'd0};
        case (cfg.line_mode)
            dtpg_pkg::LM_ODD_INDEX: line_on = (pix.y0 & cfg.w0) ^ pix.x0;
            dtpg_pkg::LM_ROWS:      line_on = pix.y0;
            default:                line_on = ~(pix.x0 ^ pix.y0);
        endcase
        case (cfg.pattern)
            dtpg_pkg::PAT_SOLID:    pixel_next = cfg.solid_on ? color : 16'd0;
            dtpg_pkg::PAT_GRADIENT: pixel_next = grad;
            dtpg_pkg::PAT_LINES:    pixel_next = line_on ? color : 16'd0;
            dtpg_pkg::PAT_CHESS: begin
                pixel_next = (pix.cx ^ pix.cy ^ cfg.odd) ? color : 16'd0;
            end
            dtpg_pkg::PAT_MARKER: begin
                pixel_next = (pix.mk_fg ^ cfg.odd) ? color : 16'd0;
            end
            default:                pixel_next = 16'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[5] && v_reg[4]) begin
            pixel_reg <= pixel_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = pixel_reg;

endmodule

// ===== hdl/dtpg_cfg.sv =====
// configuration registers and the values derived from them
`timescale 1ns / 1ps

module dtpg_cfg (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [10:0]    cfg_data,
    output dtpg_pkg::cfg_t cfg
);

    localparam logic [2:0] REG_PATTERN    = 3'd0;
    localparam logic [2:0] REG_COLOR_STEP = 3'd1;
    localparam logic [2:0] REG_PHASE      = 3'd2;
    localparam logic [2:0] REG_WIDTH      = 3'd3;
    localparam logic [2:0] REG_HEIGHT     = 3'd4;

    localparam logic [10:0] WIDTH_RST  = 11'd128;
    localparam logic [10:0] HEIGHT_RST = 11'd160;

    // ceil(2^14 / 5) and ceil(2^14 / 7), exact for 11-bit dividends
    localparam logic [22:0] RECIP5 = 23'd3277;
    localparam logic [22:0] RECIP7 = 23'd2341;

    typedef struct packed {
        dtpg_pkg::line_mode_t line_mode;
        logic                 solid_on;
        logic [2:0]           chan;
        logic [7:0]           chess_div;
        logic [10:0]          grad_div;
        logic [8:0]           col_div;
        logic [8:0]           row_div;
    } lvl1_t;

    typedef struct packed {
        logic [11:0] col1;
        logic [11:0] col2;
        logic [11:0] col4;
        logic [11:0] col5;
        logic [11:0] row1;
        logic [11:0] row2;
        logic [11:0] row3;
        logic [11:0] row4;
        logic [11:0] row5;
        logic [11:0] row6;
    } lvl2_t;

    logic [2:0]  pattern_reg;
    logic [5:0]  color_step_reg;
    logic [2:0]  phase_reg;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    lvl1_t       lvl1_reg;
    lvl1_t       lvl1_next;
    lvl2_t       lvl2_reg;
    lvl2_t       lvl2_next;

    function automatic logic [2:0] mod7(input logic [5:0] v);
        logic [3:0] s;
        s = {1'b0, v[5:3]} + {1'b0, v[2:0]};
        if (s >= 4'd14) begin
            return 3'(s - 4'd14);
        end else if (s >= 4'd7) begin
            return 3'(s - 4'd7);
        end
        return s[2:0];
    endfunction

    function automatic dtpg_pkg::line_mode_t mod3(input logic [2:0] v);
        logic [2:0] s;
        s = v;
        if (v >= 3'd6) begin
            s = v - 3'd6;
        end else if (v >= 3'd3) begin
            s = v - 3'd3;
        end
        return dtpg_pkg::line_mode_t'(s[1:0]);
    endfunction

    // channel mask {r, g, b} of each palette entry
    function automatic logic [2:0] chan_of(input logic [2:0] idx);
        logic [2:0] m;
        case (idx)
            3'd0: m = 3'b111;
            3'd1: m = 3'b100;
            3'd2: m = 3'b110;
            3'd3: m = 3'b010;
            3'd4: m = 3'b011;
            3'd5: m = 3'b001;
            3'd6: m = 3'b101;
            default: m = 3'b000;
        endcase
        return m;
    endfunction

    function automatic lvl1_t calc_lvl1(input logic [5:0] cs, input logic [2:0] ph,
                                        input logic [10:0] w, input logic [10:0] h);
        lvl1_t       r;
        logic [22:0] pw;
        logic [22:0] ph7;
        pw          = 23'(w) * RECIP5;
        ph7         = 23'(h) * RECIP7;
        r.line_mode = mod3(ph);
        r.solid_on  = (cs[2:0] != 3'd0);
        r.chan      = chan_of(mod7(cs));
        r.chess_div = (w[10:3] == 8'd0) ? 8'd1 : w[10:3];
        r.grad_div  = (h == 11'd0) ? 11'd1 : h;
        r.col_div   = (pw[22:14] == 9'd0) ? 9'd1 : pw[22:14];
        r.row_div   = (ph7[22:14] == 9'd0) ? 9'd1 : ph7[22:14];
        return r;
    endfunction

    function automatic lvl2_t calc_lvl2(input lvl1_t l);
        lvl2_t       r;
        logic [11:0] cd;
        logic [11:0] rd;
        cd     = 12'(l.col_div);
        rd     = 12'(l.row_div);
        r.col1 = cd;
        r.col2 = cd << 1;
        r.col4 = cd << 2;
        r.col5 = (cd << 2) + cd;
        r.row1 = rd;
        r.row2 = rd << 1;
        r.row3 = (rd << 1) + rd;
        r.row4 = rd << 2;
        r.row5 = (rd << 2) + rd;
        r.row6 = (rd << 2) + (rd << 1);
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg    <= 3'd0;
            color_step_reg <= 6'd0;
            phase_reg      <= 3'd0;
            width_reg      <= WIDTH_RST;
            height_reg     <= HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PATTERN:    pattern_reg    <= cfg_data[2:0];
                REG_COLOR_STEP: color_step_reg <= cfg_data[5:0];
                REG_PHASE:      phase_reg      <= cfg_data[2:0];
                REG_WIDTH:      width_reg      <= cfg_data;
                REG_HEIGHT:     height_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // after a write, derived values are registered in lvl1_reg and then in lvl2_reg
    always_comb begin
        lvl1_next = calc_lvl1(color_step_reg, phase_reg, width_reg, height_reg);
        lvl2_next = calc_lvl2(lvl1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lvl1_reg <= calc_lvl1(6'd0, 3'd0, WIDTH_RST, HEIGHT_RST);
            lvl2_reg <= calc_lvl2(calc_lvl1(6'd0, 3'd0, WIDTH_RST, HEIGHT_RST));
        end else begin
            lvl1_reg <= lvl1_next;
            lvl2_reg <= lvl2_next;
        end
    end

    always_comb begin
        cfg.pattern   = dtpg_pkg::pattern_t'(pattern_reg);
        cfg.odd       = phase_reg[0];
        cfg.w0        = width_reg[0];
        cfg.line_mode = lvl1_reg.line_mode;
        cfg.solid_on  = lvl1_reg.solid_on;
        cfg.chan      = lvl1_reg.chan;
        cfg.chess_div = lvl1_reg.chess_div;
        cfg.grad_div  = lvl1_reg.grad_div;
        cfg.col1      = lvl2_reg.col1;
        cfg.col2      = lvl2_reg.col2;
        cfg.col4      = lvl2_reg.col4;
        cfg.col5      = lvl2_reg.col5;
        cfg.row1      = lvl2_reg.row1;
        cfg.row2      = lvl2_reg.row2;
        cfg.row3      = lvl2_reg.row3;
        cfg.row4      = lvl2_reg.row4;
        cfg.row5      = lvl2_reg.row5;
        cfg.row6      = lvl2_reg.row6;
    end

endmodule

// ===== hdl/dtpg_core.sv =====
// five pipeline stages: capture, pipelined dividers and marker cell lookup
`timescale 1ns / 1ps

module dtpg_core (
    input  logic           aclk,
    input  logic [4:0]     en,
    input  logic [10:0]    pixel_x,
    input  logic [10:0]    pixel_y,
    input  dtpg_pkg::cfg_t cfg,
    output dtpg_pkg::pix_t pix
);

    // stage 1
    logic [10:0] x1_reg, y1_reg;
    logic [18:0] n1_reg;
    logic [18:0] n1_next;
    // stage 2
    logic [10:0] x2_reg, y2_reg;
    logic [7:0]  rx2_reg, ry2_reg;
    logic [10:0] rg2_reg;
    logic [5:0]  n2_reg;
    logic [1:0]  qg2_reg;
    logic        ovf2_reg;
    // stage 3
    logic [4:0]  x3_reg, y3_reg;
    logic [7:0]  rx3_reg, ry3_reg;
    logic [10:0] rg3_reg;
    logic [3:0]  n3_reg;
    logic [3:0]  qg3_reg;
    logic        ovf3_reg;
    logic        mk3_reg;
    // stage 4
    logic [1:0]  x4_reg, y4_reg;
    logic [7:0]  rx4_reg, ry4_reg;
    logic [10:0] rg4_reg;
    logic [1:0]  n4_reg;
    logic [5:0]  qg4_reg;
    logic        ovf4_reg;
    logic        mk4_reg;
    // stage 5
    dtpg_pkg::pix_t pix5_reg;

    dtpg_pkg::cdiv_t sx2a, sx2b, sx2c, sy2a, sy2b, sy2c;
    dtpg_pkg::cdiv_t sx3a, sx3b, sx3c, sy3a, sy3b, sy3c;
    dtpg_pkg::cdiv_t sx4a, sx4b, sx4c, sy4a, sy4b, sy4c;
    dtpg_pkg::cdiv_t sx5a, sx5b, sy5a, sy5b;
    dtpg_pkg::gdiv_t sg2a, sg2b, sg3a, sg3b, sg4a, sg4b, sg5a, sg5b;
    logic            ovf2_next;
    logic            mk3_next;
    logic            rg1, rg2, rg3, rg4, rg5, rg6;
    logic            cg1, cg2, cg4, cg5;

    // 255 * y
    assign n1_next = {pixel_y, 8'd0} - {8'd0, pixel_y};

    // stage 2: saturation test, two gradient steps, three chess steps
    always_comb begin
        ovf2_next = (n1_reg[18:8] >= cfg.grad_div);
        sg2a = dtpg_pkg::grad_step(n1_reg[18:8], n1_reg[7], cfg.grad_div);
        sg2b = dtpg_pkg::grad_step(sg2a.rem, n1_reg[6], cfg.grad_div);
        sx2a = dtpg_pkg::chess_step(8'd0, x1_reg[10], cfg.chess_div);
        sx2b = dtpg_pkg::chess_step(sx2a.rem, x1_reg[9], cfg.chess_div);
        sx2c = dtpg_pkg::chess_step(sx2b.rem, x1_reg[8], cfg.chess_div);
        sy2a = dtpg_pkg::chess_step(8'd0, y1_reg[10], cfg.chess_div);
        sy2b = dtpg_pkg::chess_step(sy2a.rem, y1_reg[9], cfg.chess_div);
        sy2c = dtpg_pkg::chess_step(sy2b.rem, y1_reg[8], cfg.chess_div);
    end

    // stage 3: marker cell test and the next divider steps
    always_comb begin
        cg1 = {1'b0, x2_reg} >= cfg.col1;
        cg2 = {1'b0, x2_reg} >= cfg.col2;
        cg4 = {1'b0, x2_reg} >= cfg.col4;
        cg5 = {1'b0, x2_reg} >= cfg.col5;
        rg1 = {1'b0, y2_reg} >= cfg.row1;
        rg2 = {1'b0, y2_reg} >= cfg.row2;
        rg3 = {1'b0, y2_reg} >= cfg.row3;
        rg4 = {1'b0, y2_reg} >= cfg.row4;
        rg5 = {1'b0, y2_reg} >= cfg.row5;
        rg6 = {1'b0, y2_reg} >= cfg.row6;
        // cell rows 1 and 3: all but outer columns; rows 2, 4, 5: column 1 only
        if ((rg1 && !rg2) || (rg3 && !rg4)) begin
            mk3_next = cg1 && !(cg4 && !cg5);
        end else if ((rg2 && !rg3) || (rg4 && !rg5) || (rg5 && !rg6)) begin
            mk3_next = cg1 && !cg2;
        end else begin
            mk3_next = 1'b0;
        end
        sg3a = dtpg_pkg::grad_step(rg2_reg, n2_reg[5], cfg.grad_div);
        sg3b = dtpg_pkg::grad_step(sg3a.rem, n2_reg[4], cfg.grad_div);
        sx3a = dtpg_pkg::chess_step(rx2_reg, x2_reg[7], cfg.chess_div);
        sx3b = dtpg_pkg::chess_step(sx3a.rem, x2_reg[6], cfg.chess_div);
        sx3c = dtpg_pkg::chess_step(sx3b.rem, x2_reg[5], cfg.chess_div);
        sy3a = dtpg_pkg::chess_step(ry2_reg, y2_reg[7], cfg.chess_div);
        sy3b = dtpg_pkg::chess_step(sy3a.rem, y2_reg[6], cfg.chess_div);
        sy3c = dtpg_pkg::chess_step(sy3b.rem, y2_reg[5], cfg.chess_div);
    end

    // stage 4
    always_comb begin
        sg4a = dtpg_pkg::grad_step(rg3_reg, n3_reg[3], cfg.grad_div);
        sg4b = dtpg_pkg::grad_step(sg4a.rem, n3_reg[2], cfg.grad_div);
        sx4a = dtpg_pkg::chess_step(rx3_reg, x3_reg[4], cfg.chess_div);
        sx4b = dtpg_pkg::chess_step(sx4a.rem, x3_reg[3], cfg.chess_div);
        sx4c = dtpg_pkg::chess_step(sx4b.rem, x3_reg[2], cfg.chess_div);
        sy4a = dtpg_pkg::chess_step(ry3_reg, y3_reg[4], cfg.chess_div);
        sy4b = dtpg_pkg::chess_step(sy4a.rem, y3_reg[3], cfg.chess_div);
        sy4c = dtpg_pkg::chess_step(sy4b.rem, y3_reg[2], cfg.chess_div);
    end

    // stage 5: last steps, only the quotient lsb of the chess dividers is kept
    always_comb begin
        sg5a = dtpg_pkg::grad_step(rg4_reg, n4_reg[1], cfg.grad_div);
        sg5b = dtpg_pkg::grad_step(sg5a.rem, n4_reg[0], cfg.grad_div);
        sx5a = dtpg_pkg::chess_step(rx4_reg, x4_reg[1], cfg.chess_div);
        sx5b = dtpg_pkg::chess_step(sx5a.rem, x4_reg[0], cfg.chess_div);
        sy5a = dtpg_pkg::chess_step(ry4_reg, y4_reg[1], cfg.chess_div);
        sy5b = dtpg_pkg::chess_step(sy5a.rem, y4_reg[0], cfg.chess_div);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            x1_reg <= pixel_x;
            y1_reg <= pixel_y;
            n1_reg <= n1_next;
        end
        if (en[1]) begin
            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            rx2_reg  <= sx2c.rem;
            ry2_reg  <= sy2c.rem;
            rg2_reg  <= sg2b.rem;
            n2_reg   <= n1_reg[5:0];
            qg2_reg  <= {sg2a.q, sg2b.q};
            ovf2_reg <= ovf2_next;
        end
        if (en[2]) begin
            x3_reg   <= x2_reg[4:0];
            y3_reg   <= y2_reg[4:0];
            rx3_reg  <= sx3c.rem;
            ry3_reg  <= sy3c.rem;
            rg3_reg  <= sg3b.rem;
            n3_reg   <= n2_reg[3:0];
            qg3_reg  <= {qg2_reg, sg3a.q, sg3b.q};
            ovf3_reg <= ovf2_reg;
            mk3_reg  <= mk3_next;
        end
        if (en[3]) begin
            x4_reg   <= x3_reg[1:0];
            y4_reg   <= y3_reg[1:0];
            rx4_reg  <= sx4c.rem;
            ry4_reg  <= sy4c.rem;
            rg4_reg  <= sg4b.rem;
            n4_reg   <= n3_reg[1:0];
            qg4_reg  <= {qg3_reg, sg4a.q, sg4b.q};
            ovf4_reg <= ovf3_reg;
            mk4_reg  <= mk3_reg;
        end
        if (en[4]) begin
            pix5_reg.cx    <= sx5b.q;
            pix5_reg.cy    <= sy5b.q;
            pix5_reg.gq    <= {qg4_reg, sg5a.q, sg5b.q};
            pix5_reg.govf  <= ovf4_reg;
            pix5_reg.mk_fg <= mk4_reg;
            pix5_reg.x0    <= x4_reg[0];
            pix5_reg.y0    <= y4_reg[0];
        end
    end

    assign pix = pix5_reg;

endmodule
